/* rtl/segment_view_cone_clip_assert.svh */
// Assertion helpers for the clipper RTL.
`ifndef SEGMENT_VIEW_CONE_CLIP_ASSERT_SVH
`define SEGMENT_VIEW_CONE_CLIP_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define SVCC_ASSERT_SAME(label, clk, rst, trig, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
      else $error("svcc assertion failed");

// The condition holds in the cycle after the trigger.
`define SVCC_ASSERT_NEXT(label, clk, rst, trig, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
      else $error("svcc assertion failed");

`endif

/* rtl/svcc_pkg.sv */
package svcc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int PLANE_COUNT = 5;
   localparam int T_BITS      = 31;
   localparam int DIFF_W      = 33;
   localparam int DOT_W       = (FRAC_BITS + 46 > 66) ? FRAC_BITS + 46 : 66;
   localparam int REM_W       = DOT_W + T_BITS;
   localparam int PROD_W      = T_BITS + DIFF_W;

   localparam logic [T_BITS-1:0] T_MAX = '1;

   localparam logic [30:0]        SCREEN_DIST_RESET = 31'd26214400;
   localparam logic [11:0]        HALF_WIDTH_RESET  = 12'd320;
   localparam logic [11:0]        HALF_HEIGHT_RESET = 12'd240;
   localparam logic signed [31:0] NEAR_Z_RESET      = 32'sd65536;

   typedef enum logic [1:0] {
      REG_SCREEN_DIST = 2'd0,
      REG_HALF_WIDTH  = 2'd1,
      REG_HALF_HEIGHT = 2'd2,
      REG_NEAR_Z      = 2'd3
   } svcc_reg_type;

   typedef logic signed [DOT_W-1:0] svcc_dot_type;
   typedef logic [DOT_W-1:0]        svcc_mag_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } svcc_req_type;

   typedef struct packed {
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_z;
      logic [30:0]        hit_param;
      logic               no_hit;
   } svcc_rsp_type;

   typedef struct packed {
      logic [30:0]        screen_dist;
      logic [11:0]        half_width;
      logic [11:0]        half_height;
      logic signed [31:0] near_z;
   } svcc_cfg_type;

   typedef struct packed {
      logic signed [31:0]       sx;
      logic signed [31:0]       sy;
      logic signed [31:0]       sz;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
   } svcc_geo_type;

   typedef struct packed {
      logic              ok;
      logic              sat;
      logic [REM_W-1:0]  rem;
      logic [DOT_W-1:0]  den;
      logic [T_BITS-1:0] quo;
   } svcc_lane_type;

   typedef struct packed {
      svcc_geo_type                         geo;
      svcc_lane_type [PLANE_COUNT-1:0]      lane;
   } svcc_stage_type;

endpackage

/* rtl/svcc_front.sv */
module svcc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    req_valid,
   input  svcc_pkg::svcc_req_type  req_payload,
   input  svcc_pkg::svcc_cfg_type  cfg,
   output logic                    out_valid,
   output svcc_pkg::svcc_stage_type out_stage
);
   import svcc_pkg::*;

   localparam int P_DQX  = 0;
   localparam int P_DQY  = 1;
   localparam int P_WZ   = 2;
   localparam int P_HZ   = 3;
   localparam int P_DQDX = 4;
   localparam int P_DQDY = 5;
   localparam int P_WDZ  = 6;
   localparam int P_HDZ  = 7;

   logic [3:0]      vld_ff;
   logic            out_valid_ff;
   svcc_geo_type    geo_in;
   svcc_geo_type    geo_ff [4];
   svcc_dot_type    a_z_in, a_nn_in;
   svcc_dot_type    a_z_ff, a_nn_ff;
   svcc_dot_type    dq, hw, hh;
   svcc_dot_type    b_prod_in [8];
   svcc_dot_type    b_prod_ff [8];
   svcc_dot_type    b_nn_ff;
   svcc_dot_type    c_num_in [PLANE_COUNT];
   svcc_dot_type    c_den_in [PLANE_COUNT];
   svcc_dot_type    c_num_ff [PLANE_COUNT];
   svcc_dot_type    c_den_ff [PLANE_COUNT];
   logic            d_ok_in  [PLANE_COUNT];
   svcc_mag_type    d_nmag_in [PLANE_COUNT];
   svcc_mag_type    d_dmag_in [PLANE_COUNT];
   logic            d_ok_ff  [PLANE_COUNT];
   svcc_mag_type    d_nmag_ff [PLANE_COUNT];
   svcc_mag_type    d_dmag_ff [PLANE_COUNT];
   svcc_stage_type  out_stage_in;
   svcc_stage_type  out_stage_ff;

   // Stage A: differences and plane offsets.
   always_comb begin
      geo_in.sx = req_payload.start_x;
      geo_in.sy = req_payload.start_y;
      geo_in.sz = req_payload.start_z;
      geo_in.dx = {req_payload.end_x[31], req_payload.end_x}
                - {req_payload.start_x[31], req_payload.start_x};
      geo_in.dy = {req_payload.end_y[31], req_payload.end_y}
                - {req_payload.start_y[31], req_payload.start_y};
      geo_in.dz = {req_payload.end_z[31], req_payload.end_z}
                - {req_payload.start_z[31], req_payload.start_z};
      a_z_in  = svcc_dot_type'(req_payload.start_z) + dq;
      a_nn_in = svcc_dot_type'(cfg.near_z) - svcc_dot_type'(req_payload.start_z);
   end

   // Stage B: products of normals and segment terms.
   always_comb begin
      dq = svcc_dot_type'({1'b0, cfg.screen_dist});
      hw = svcc_dot_type'({1'b0, cfg.half_width});
      hh = svcc_dot_type'({1'b0, cfg.half_height});
      b_prod_in[P_DQX]  = dq * svcc_dot_type'(geo_ff[0].sx);
      b_prod_in[P_DQY]  = dq * svcc_dot_type'(geo_ff[0].sy);
      b_prod_in[P_WZ]   = (hw * a_z_ff) <<< FRAC_BITS;
      b_prod_in[P_HZ]   = (hh * a_z_ff) <<< FRAC_BITS;
      b_prod_in[P_DQDX] = dq * svcc_dot_type'(geo_ff[0].dx);
      b_prod_in[P_DQDY] = dq * svcc_dot_type'(geo_ff[0].dy);
      b_prod_in[P_WDZ]  = (hw * svcc_dot_type'(geo_ff[0].dz)) <<< FRAC_BITS;
      b_prod_in[P_HDZ]  = (hh * svcc_dot_type'(geo_ff[0].dz)) <<< FRAC_BITS;
   end

   // Stage C: numerator and denominator of each plane, near plane first.
   always_comb begin
      c_num_in[0] = b_nn_ff;
      c_den_in[0] = svcc_dot_type'(geo_ff[1].dz);
      c_num_in[1] = -(b_prod_ff[P_DQY] + b_prod_ff[P_HZ]);
      c_den_in[1] = b_prod_ff[P_DQDY] + b_prod_ff[P_HDZ];
      c_num_in[2] = b_prod_ff[P_WZ] - b_prod_ff[P_DQX];
      c_den_in[2] = b_prod_ff[P_DQDX] - b_prod_ff[P_WDZ];
      c_num_in[3] = b_prod_ff[P_HZ] - b_prod_ff[P_DQY];
      c_den_in[3] = b_prod_ff[P_DQDY] - b_prod_ff[P_HDZ];
      c_num_in[4] = -(b_prod_ff[P_DQX] + b_prod_ff[P_WZ]);
      c_den_in[4] = b_prod_ff[P_DQDX] + b_prod_ff[P_WDZ];
   end

   // Stage D: a plane counts when it is not parallel and t is not negative.
   always_comb begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
         d_ok_in[i]   = (c_den_ff[i] != '0) &&
                        ((c_num_ff[i] == '0) ||
                         (c_num_ff[i][DOT_W-1] == c_den_ff[i][DOT_W-1]));
         d_nmag_in[i] = c_num_ff[i][DOT_W-1] ? svcc_mag_type'(-c_num_ff[i])
                                             : svcc_mag_type'(c_num_ff[i]);
         d_dmag_in[i] = c_den_ff[i][DOT_W-1] ? svcc_mag_type'(-c_den_ff[i])
                                             : svcc_mag_type'(c_den_ff[i]);
      end
   end

   // Stage E: saturation test and the divider's starting remainder.
   always_comb begin
      out_stage_in.geo = geo_ff[3];
      for (int i = 0; i < PLANE_COUNT; i++) begin
         out_stage_in.lane[i].ok  = d_ok_ff[i];
         out_stage_in.lane[i].sat = REM_W'(d_nmag_ff[i]) >=
                                    (REM_W'(d_dmag_ff[i]) << (T_BITS - FRAC_BITS));
         out_stage_in.lane[i].rem = REM_W'(d_nmag_ff[i]) << FRAC_BITS;
         out_stage_in.lane[i].den = d_dmag_ff[i];
         out_stage_in.lane[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[2:0], req_valid};
         out_valid_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo_ff[0] <= geo_in;
         for (int k = 1; k < 4; k++) begin
            geo_ff[k] <= geo_ff[k-1];
         end
         a_z_ff  <= a_z_in;
         a_nn_ff <= a_nn_in;
         b_prod_ff <= b_prod_in;
         b_nn_ff   <= a_nn_ff;
         c_num_ff  <= c_num_in;
         c_den_ff  <= c_den_in;
         d_ok_ff   <= d_ok_in;
         d_nmag_ff <= d_nmag_in;
         d_dmag_ff <= d_dmag_in;
         out_stage_ff <= out_stage_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_stage = out_stage_ff;

endmodule

/* rtl/svcc_cell.sv */
module svcc_cell #(
   parameter int BIT = svcc_pkg::T_BITS - 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  svcc_pkg::svcc_stage_type in_stage,
   output logic                     out_valid,
   output svcc_pkg::svcc_stage_type out_stage
);
   import svcc_pkg::*;

   logic             out_valid_ff;
   svcc_stage_type   out_stage_in;
   svcc_stage_type   out_stage_ff;
   logic [REM_W-1:0] trial [PLANE_COUNT];

   // One restoring step per plane: this cell settles quotient bit BIT.
   always_comb begin
      out_stage_in = in_stage;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         trial[i] = REM_W'(in_stage.lane[i].den) << BIT;
         if (in_stage.lane[i].rem >= trial[i]) begin
            out_stage_in.lane[i].rem      = in_stage.lane[i].rem - trial[i];
            out_stage_in.lane[i].quo[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_stage_ff <= out_stage_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_stage = out_stage_ff;

endmodule

/* rtl/svcc_back.sv */
module svcc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  svcc_pkg::svcc_stage_type in_stage,
   input  logic                     rsp_stall,
   output logic                     adv,
   output logic                     rsp_valid,
   output svcc_pkg::svcc_rsp_type   rsp_payload
);
   import svcc_pkg::*;

   localparam int PT_W = PROD_W - FRAC_BITS + 2;

   logic                 p_valid_ff, q_valid_ff, rsp_valid_ff;
   logic                 load;
   logic [T_BITS-1:0]    p_best_in, p_best_ff, q_best_ff;
   logic                 p_hit_in, p_hit_ff, q_hit_ff;
   logic [T_BITS-1:0]    t_lane;
   svcc_geo_type         p_geo_ff;
   logic signed [31:0]   q_s_ff [3];
   logic                 q_neg_ff [3];
   logic [PROD_W-1:0]    q_prod_in [3];
   logic [PROD_W-1:0]    q_prod_ff [3];
   logic signed [DIFF_W-1:0] dsel [3];
   logic signed [31:0]   ssel [3];
   logic [DIFF_W-1:0]    dmag [3];
   logic signed [PT_W-1:0] sum [3];
   logic signed [PT_W-1:0] step;
   logic signed [31:0]   coord [3];
   svcc_rsp_type         rsp_in, rsp_ff;

   // Earliest plane with strictly smaller t wins.
   always_comb begin
      p_best_in = T_MAX;
      p_hit_in  = 1'b0;
      t_lane    = '0;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         t_lane = in_stage.lane[i].sat ? T_MAX : in_stage.lane[i].quo;
         if (in_stage.lane[i].ok && (!p_hit_in || (t_lane < p_best_in))) begin
            p_best_in = t_lane;
            p_hit_in  = 1'b1;
         end
      end
   end

   always_comb begin
      dsel[0] = p_geo_ff.dx;  dsel[1] = p_geo_ff.dy;  dsel[2] = p_geo_ff.dz;
      ssel[0] = p_geo_ff.sx;  ssel[1] = p_geo_ff.sy;  ssel[2] = p_geo_ff.sz;
      for (int k = 0; k < 3; k++) begin
         dmag[k]      = dsel[k][DIFF_W-1] ? DIFF_W'(-dsel[k]) : DIFF_W'(dsel[k]);
         q_prod_in[k] = PROD_W'(p_best_ff) * PROD_W'(dmag[k]);
      end
   end

   // Step truncated toward zero, then clamped to 32 bits.
   always_comb begin
      step = '0;
      for (int k = 0; k < 3; k++) begin
         step   = PT_W'(q_prod_ff[k] >> FRAC_BITS);
         sum[k] = q_neg_ff[k] ? PT_W'(q_s_ff[k]) - step : PT_W'(q_s_ff[k]) + step;
         if (sum[k][PT_W-1:31] == {(PT_W-31){sum[k][31]}}) begin
            coord[k] = sum[k][31:0];
         end else if (sum[k][PT_W-1]) begin
            coord[k] = 32'sh8000_0000;
         end else begin
            coord[k] = 32'sh7FFF_FFFF;
         end
      end
      rsp_in.hit_x     = coord[0];
      rsp_in.hit_y     = coord[1];
      rsp_in.hit_z     = coord[2];
      rsp_in.hit_param = q_best_ff;
      rsp_in.no_hit    = !q_hit_ff;
   end

   assign load = !rsp_valid_ff || !rsp_stall;
   assign adv  = load || !q_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         q_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            p_valid_ff <= in_valid;
            q_valid_ff <= p_valid_ff;
         end
         if (load) begin
            rsp_valid_ff <= q_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_best_ff <= p_best_in;
         p_hit_ff  <= p_hit_in;
         p_geo_ff  <= in_stage.geo;
         q_best_ff <= p_best_ff;
         q_hit_ff  <= p_hit_ff;
         q_prod_ff <= q_prod_in;
         q_s_ff    <= ssel;
         for (int k = 0; k < 3; k++) begin
            q_neg_ff[k] <= dsel[k][DIFF_W-1];
         end
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/segment_view_cone_clip.sv */
// Segment clipper against a viewing cone. Each request carries a segment from a
// start to an end point in signed Q16.16; the block intersects it with the near
// plane and the four side planes through the eye point and the screen corners,
// keeps the smallest non-negative line parameter t (ties go to the earlier
// plane, near plane first) and returns t and the point start + t*(end-start),
// both saturated. When no plane is hit, no_hit is set and t reads as all ones.
// One request is taken every clock cycle while the pipeline is not stalled; five
// front stages form the plane equations, a chain of 31 divider cells settles one
// bit of each plane's quotient per cycle, and three back stages pick the plane,
// scale the direction and clamp the point. Registers on
// the csr port are written with two-cycle writes and must only be changed
// while no request is in flight.
`include "segment_view_cone_clip_assert.svh"

module segment_view_cone_clip (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  svcc_pkg::svcc_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output svcc_pkg::svcc_rsp_type rsp_payload,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import svcc_pkg::*;

   logic [30:0]        screen_dist_ff;
   logic [11:0]        half_width_ff;
   logic [11:0]        half_height_ff;
   logic signed [31:0] near_z_ff;
   logic               csr_write;
   svcc_reg_type       csr_index;
   svcc_cfg_type       cfg;
   logic               adv;
   logic [T_BITS:0]    chain_valid;
   svcc_stage_type     chain_stage [T_BITS+1];

   // The register file. pready is tied high, so every access completes in
   // its access cycle.
   assign csr_pready = 1'b1;
   assign csr_index  = svcc_reg_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_dist_ff <= SCREEN_DIST_RESET;
         half_width_ff  <= HALF_WIDTH_RESET;
         half_height_ff <= HALF_HEIGHT_RESET;
         near_z_ff      <= NEAR_Z_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCREEN_DIST: screen_dist_ff <= csr_pwdata[30:0];
            REG_HALF_WIDTH:  half_width_ff  <= csr_pwdata[11:0];
            REG_HALF_HEIGHT: half_height_ff <= csr_pwdata[11:0];
            REG_NEAR_Z:      near_z_ff      <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SCREEN_DIST: csr_prdata = {1'b0, screen_dist_ff};
         REG_HALF_WIDTH:  csr_prdata = {20'd0, half_width_ff};
         REG_HALF_HEIGHT: csr_prdata = {20'd0, half_height_ff};
         REG_NEAR_Z:      csr_prdata = near_z_ff;
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.screen_dist = screen_dist_ff;
      cfg.half_width  = half_width_ff;
      cfg.half_height = half_height_ff;
      cfg.near_z      = near_z_ff;
   end

   // The whole pipeline moves together. It stops only when the output
   // register holds a result that is being stalled and the last internal
   // stage is also full, so a bubble in front of the output is always
   // squeezed out and a new request can still be taken.
   assign req_stall = !adv;

   svcc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .cfg         (cfg),
      .out_valid   (chain_valid[0]),
      .out_stage   (chain_stage[0])
   );

   // Divider chain: the first cell decides the most significant bit of t.
   for (genvar g = 0; g < T_BITS; g++) begin : g_cell
      svcc_cell #(
         .BIT (T_BITS - 1 - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[g]),
         .in_stage  (chain_stage[g]),
         .out_valid (chain_valid[g+1]),
         .out_stage (chain_stage[g+1])
      );
   end

   svcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[T_BITS]),
      .in_stage    (chain_stage[T_BITS]),
      .rsp_stall   (rsp_stall),
      .adv         (adv),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A miss always reports the saturated parameter.
   `SVCC_ASSERT_SAME(a_miss_param, clock, reset, rsp_valid && rsp_payload.no_hit, rsp_payload.hit_param == T_MAX)
   // Requests are held back only while a finished result is itself stalled.
   `SVCC_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // A write to the eye distance lands in the register in the next cycle.
   `SVCC_ASSERT_NEXT(a_dist_write, clock, reset, csr_write && (csr_index == REG_SCREEN_DIST), screen_dist_ff == $past(csr_pwdata[30:0]))

endmodule

/* test/segment_view_cone_clip_tb.sv */
module segment_view_cone_clip_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svcc_pkg::*;

   // Clip predictor and the queue of clipped points still awaited from the block.
   class clip_scoreboard;
      svcc_cfg_type  view;
      svcc_rsp_type  awaited[$];
      int            mismatches;
      int            seen;
      int            misses;

      function new();
         view.screen_dist = SCREEN_DIST_RESET;
         view.half_width  = HALF_WIDTH_RESET;
         view.half_height = HALF_HEIGHT_RESET;
         view.near_z      = NEAR_Z_RESET;
      endfunction

      function void set_view(svcc_cfg_type c);
         view = c;
      endfunction

      function logic signed [31:0] clamp32(logic signed [127:0] v);
         if (v > 128'sd2147483647) return 32'h7FFFFFFF;
         if (v < -128'sd2147483648) return 32'h80000000;
         return v[31:0];
      endfunction

      function svcc_rsp_type clip(svcc_req_type r);
         logic signed [127:0] s[3], d[3], nrm[5][3], pz[5];
         logic signed [127:0] num, den, an, ad, q, w, step, dq, wq, hq;
         logic [30:0]         best;
         bit                  hit;
         svcc_rsp_type        o;
         dq = {97'd0, view.screen_dist};
         wq = {100'd0, view.half_width, 16'd0};
         hq = {100'd0, view.half_height, 16'd0};
         s[0] = $signed(r.start_x);
         s[1] = $signed(r.start_y);
         s[2] = $signed(r.start_z);
         d[0] = $signed(r.end_x) - s[0];
         d[1] = $signed(r.end_y) - s[1];
         d[2] = $signed(r.end_z) - s[2];
         // Near plane first, then the four side planes through the eye point.
         nrm[0] = '{0, 0, 1};    pz[0] = $signed(view.near_z);
         nrm[1] = '{0, dq, hq};  pz[1] = -dq;
         nrm[2] = '{dq, 0, -wq}; pz[2] = -dq;
         nrm[3] = '{0, dq, -hq}; pz[3] = -dq;
         nrm[4] = '{dq, 0, wq};  pz[4] = -dq;
         best = T_MAX;
         hit  = 0;
         for (int i = 0; i < PLANE_COUNT; i++) begin
            num = 0;
            den = 0;
            for (int k = 0; k < 3; k++) begin
               w = (k == 2) ? s[k] - pz[i] : s[k];
               num += nrm[i][k] * w;
               den += nrm[i][k] * d[k];
            end
            num = -num;
            if (den == 0) continue;
            if (num != 0 && ((num < 0) != (den < 0))) continue;
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q  = (an <<< FRAC_BITS) / ad;
            if (q > $signed({97'd0, T_MAX})) q = {97'd0, T_MAX};
            if (!hit || q[30:0] < best) begin
               best = q[30:0];
               hit  = 1;
            end
         end
         for (int k = 0; k < 3; k++) begin
            step = ({97'd0, best} * ((d[k] < 0) ? -d[k] : d[k])) >>> FRAC_BITS;
            w = (d[k] < 0) ? s[k] - step : s[k] + step;
            case (k)
               0: o.hit_x = clamp32(w);
               1: o.hit_y = clamp32(w);
               default: o.hit_z = clamp32(w);
            endcase
         end
         o.hit_param = best;
         o.no_hit    = !hit;
         return o;
      endfunction

      function void note_request(svcc_req_type r);
         awaited.push_back(clip(r));
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_result(svcc_rsp_type got);
         svcc_rsp_type want;
         seen++;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected result %h", got));
            return;
         end
         want = awaited.pop_front();
         if (want.no_hit) misses++;
         if (got.hit_x !== want.hit_x)
            flag($sformatf("hit_x exp %h got %h", want.hit_x, got.hit_x));
         if (got.hit_y !== want.hit_y)
            flag($sformatf("hit_y exp %h got %h", want.hit_y, got.hit_y));
         if (got.hit_z !== want.hit_z)
            flag($sformatf("hit_z exp %h got %h", want.hit_z, got.hit_z));
         if (got.hit_param !== want.hit_param)
            flag($sformatf("hit_param exp %h got %h", want.hit_param, got.hit_param));
         if (got.no_hit !== want.no_hit)
            flag($sformatf("no_hit exp %b got %b", want.no_hit, got.no_hit));
      endfunction
   endclass

   localparam int LATENCY     = 39;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD   = 250;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   svcc_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   svcc_rsp_type rsp_payload;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   clip_scoreboard board = new();
   bit             idling = 1;
   bit             long_hold;
   int             quiet_cycles;
   int             sent;

   segment_view_cone_clip dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Every request and every result that crosses its handshake is seen here, at
   // the edge itself, so the values sampled are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request(req_payload);
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_payload);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver stalls in random bursts while idling. On request it holds off
   // for a long stretch so that the pipeline fills and pushes back on the sender.
   initial begin
      rsp_stall = 0;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 0;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   // Offers one request, possibly after a random gap, and waits until it is taken.
   task automatic send_segment(svcc_req_type r);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid   <= 1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic write_register(svcc_reg_type idx, logic [31:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   // Registers only change once every result is back and the pipeline has had
   // time to empty.
   task automatic wait_idle();
      req_valid <= 0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_view(logic [30:0] eye_dist, logic [11:0] hw, logic [11:0] hh,
                           logic [31:0] nz);
      svcc_cfg_type c;
      c.screen_dist = eye_dist;
      c.half_width  = hw;
      c.half_height = hh;
      c.near_z      = nz;
      write_register(REG_SCREEN_DIST, {1'b0, eye_dist});
      write_register(REG_HALF_WIDTH, {20'd0, hw});
      write_register(REG_HALF_HEIGHT, {20'd0, hh});
      write_register(REG_NEAR_Z, nz);
      board.set_view(c);
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: case ($urandom_range(0, 4))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         // Mostly on-screen sized coordinates, in pixels with a random fraction.
         default: return ($signed($urandom_range(0, 1600)) - 800) * 65536
                         + $signed($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random(int count);
      svcc_req_type r;
      repeat (count) begin
         r.start_x = pick_coord();
         r.start_y = pick_coord();
         r.start_z = pick_coord();
         r.end_x   = pick_coord();
         r.end_y   = pick_coord();
         r.end_z   = pick_coord();
         case ($urandom_range(0, 9))
            // Zero-length segment.
            0: begin
               r.end_x = r.start_x;
               r.end_y = r.start_y;
               r.end_z = r.start_z;
            end
            // Segment parallel to the near plane.
            1: r.end_z = r.start_z;
            // A typical view ray: from in front of the eye out past the screen.
            2, 3, 4: begin
               r.start_z = $signed($urandom_range(0, 200)) * 65536 - 100 * 65536;
               r.end_z   = $signed($urandom_range(0, 4000)) * 65536;
            end
            default: ;
         endcase
         send_segment(r);
      end
   endtask

   task automatic send_directed();
      svcc_req_type r;
      svcc_req_type list[$];
      list.push_back('{0, 0, 0, 0, 0, 0});
      list.push_back('{0, 0, -65536, 0, 0, 10 * 65536});
      list.push_back('{0, 0, 10 * 65536, 0, 0, -65536});
      list.push_back('{5 * 65536, 5 * 65536, 0, 5 * 65536, 5 * 65536, 0});
      list.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                       32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
      list.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                       32'sh80000000, 32'sh80000000, 32'sh80000000});
      list.push_back('{0, 0, 32'sh80000000, 0, 0, 32'sh7FFFFFFF});
      list.push_back('{0, 0, 0, 1000 * 65536, 0, 0});
      list.push_back('{0, 0, 0, -1000 * 65536, 0, 0});
      list.push_back('{0, 0, 0, 0, 1000 * 65536, 0});
      list.push_back('{0, 0, 0, 0, -1000 * 65536, 0});
      list.push_back('{0, 0, -400 * 65536, 0, 0, -800 * 65536});
      list.push_back('{0, 0, 65536, 0, 0, 2 * 65536});
      list.push_back('{-1, -1, -1, -1, -1, -1});
      list.push_back('{1, 1, 1, 1, 1, 1});
      list.push_back('{320 * 65536, 240 * 65536, 0, 640 * 65536, 480 * 65536,
                       400 * 65536});
      list.push_back('{0, 0, -65536, 1, 1, 0});
      list.push_back('{32'sh7FFFFFFF, 0, 0, 32'sh80000000, 0, 0});
      foreach (list[i]) send_segment(list[i]);
   endtask

   initial begin
      reset       = 1;
      req_valid   = 0;
      req_payload = '0;
      csr_psel    = 0;
      csr_penable = 0;
      csr_pwrite  = 0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Power-on view first, then a run of settings out to the extremes; the
      // last one runs with no gaps on either side.
      set_view(SCREEN_DIST_RESET, HALF_WIDTH_RESET, HALF_HEIGHT_RESET, NEAR_Z_RESET);
      send_directed();
      send_random(296);
      wait_idle();

      set_view(31'h7FFFFFFF, 12'd4095, 12'd4095, 32'h80000000);
      long_hold = 1;
      send_directed();
      send_random(200);
      wait_idle();

      set_view(31'd0, 12'd1, 12'd1, 32'h7FFFFFFF);
      send_random(150);
      wait_idle();

      set_view(31'd65536, 12'd0, 12'd0, 32'd0);
      send_random(150);
      wait_idle();

      set_view(31'd6553600, 12'd4095, 12'd1, -32'sd65536 * 50);
      send_random(200);
      wait_idle();

      idling = 0;
      set_view(SCREEN_DIST_RESET, 12'd1, 12'd4095, 32'd65536);
      send_directed();
      send_random(250);
      req_valid <= 0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d segments over six view settings, %0d with no plane hit",
               sent, board.misses);
      $display("results checked %0d, mismatches %0d", board.seen, board.mismatches);
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
